/* rtl/binary_keyvalue_stream_parser_defines.svh */
// assertion macros for the binary key-value stream parser
// expects aclk and aresetn in the scope of each use
`ifndef BINARY_KEYVALUE_STREAM_PARSER_DEFINES_SVH
`define BINARY_KEYVALUE_STREAM_PARSER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BKV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bkv check failed");

// antecedent implies consequent in the next cycle
`define BKV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bkv check failed");

`endif

/* rtl/bkv_pkg.sv */
// shared types and codes for the binary key-value stream parser
// no dependencies
`default_nettype none

package bkv_pkg;

    localparam int DEPTH_BITS = 8;

    localparam logic [1:0] PH_TYPE  = 2'd0;
    localparam logic [1:0] PH_NAME  = 2'd1;
    localparam logic [1:0] PH_KEY   = 2'd2;
    localparam logic [1:0] PH_VALUE = 2'd3;

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_TRUNC   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_DEPTH   = 3'd4;

    localparam logic [7:0] TYPE_OPEN  = 8'h00;
    localparam logic [7:0] TYPE_PAIR  = 8'h01;
    localparam logic [7:0] TYPE_CLOSE = 8'h08;
    localparam logic [7:0] CHAR_TERM  = 8'h00;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_value;
        logic       string_end;
        logic       pair_done;
        logic       finished;
        logic [2:0] parse_status;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

`default_nettype wire

/* rtl/binary_keyvalue_stream_parser.sv */
// results are registered in the result queue before they are offered
// throughput: one byte per cycle while the result queue has room; a byte giving
// a character and a status produces two results, the four-entry result queue absorbs them
// reset: synchronous active-low aresetn clears parse state and empties the queue
// depends on bkv_pkg, bkv_core, bkv_rfifo
`default_nettype none

module binary_keyvalue_stream_parser (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_in_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_char_byte,
    output logic            m_is_value,
    output logic            m_string_end,
    output logic            m_pair_done,
    output logic            m_finished,
    output logic [2:0]      m_parse_status
);
    import bkv_pkg::*;

    push_t   push;
    result_t out_res;
    logic    room;
    logic    accept;

    assign s_ready = room;
    assign accept  = s_valid && room;

    bkv_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .push    (push)
    );

    bkv_rfifo u_rfifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_char_byte    = out_res.char_byte;
    assign m_is_value     = out_res.is_value;
    assign m_string_end   = out_res.string_end;
    assign m_pair_done    = out_res.pair_done;
    assign m_finished     = out_res.finished;
    assign m_parse_status = out_res.parse_status;

endmodule

`default_nettype wire

/* rtl/bkv_core.sv */
// parse state and per-byte decode, producing up to two results per request
// depends on bkv_pkg
`default_nettype none

module bkv_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_last,
    output bkv_pkg::push_t      push
);
    import bkv_pkg::*;

    logic [1:0]            phase_reg, phase_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic                  stopped_reg, stopped_next;
    logic                  has_char;
    logic [2:0]            st;
    result_t               char_res, stat_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TYPE;
            depth_reg   <= '0;
            stopped_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            depth_reg   <= depth_next;
            stopped_reg <= stopped_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        depth_next   = depth_reg;
        stopped_next = stopped_reg;
        has_char     = 1'b0;
        st           = ST_RUN;
        char_res     = '0;
        char_res.char_byte  = in_byte;
        char_res.string_end = (in_byte == CHAR_TERM);
        if (accept) begin
            if (stopped_reg) begin
                if (in_last) begin
                    phase_next   = PH_TYPE;
                    depth_next   = '0;
                    stopped_next = 1'b0;
                end
            end else begin
                case (phase_reg)
                    PH_TYPE: begin
                        if (in_byte == TYPE_CLOSE) begin
                            if (depth_reg == '0) begin
                                st = ST_OK;
                            end else begin
                                depth_next = depth_reg - DEPTH_BITS'(1);
                            end
                        end else if (in_byte == TYPE_OPEN) begin
                            phase_next = PH_NAME;
                        end else if (in_byte == TYPE_PAIR) begin
                            phase_next = PH_KEY;
                        end else begin
                            st = ST_UNKNOWN;
                        end
                    end
                    PH_NAME: begin
                        if (in_byte == CHAR_TERM) begin
                            if (depth_reg == '1) begin
                                st = ST_DEPTH;
                            end else begin
                                depth_next = depth_reg + DEPTH_BITS'(1);
                                phase_next = PH_TYPE;
                            end
                        end
                    end
                    PH_KEY: begin
                        has_char = 1'b1;
                        if (in_byte == CHAR_TERM) begin
                            phase_next = PH_VALUE;
                        end
                    end
                    default: begin
                        has_char           = 1'b1;
                        char_res.is_value  = 1'b1;
                        char_res.pair_done = (in_byte == CHAR_TERM);
                        if (in_byte == CHAR_TERM) begin
                            phase_next = PH_TYPE;
                        end
                    end
                endcase
                if (st == ST_RUN && in_last) begin
                    st = (phase_next == PH_TYPE) ? ST_OK : ST_TRUNC;
                end
                if (st != ST_RUN) begin
                    if (in_last) begin
                        phase_next   = PH_TYPE;
                        depth_next   = '0;
                        stopped_next = 1'b0;
                    end else begin
                        stopped_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        stat_res              = '0;
        stat_res.finished     = 1'b1;
        stat_res.parse_status = st;
        push.cnt  = {1'b0, has_char} + {1'b0, (st != ST_RUN)};
        push.res0 = has_char ? char_res : stat_res;
        push.res1 = stat_res;
    end

endmodule

`default_nettype wire

/* rtl/bkv_rfifo.sv */
// four-entry result queue, up to two writes and one read per cycle
// depends on bkv_pkg and binary_keyvalue_stream_parser_defines.svh
`default_nettype none

`include "binary_keyvalue_stream_parser_defines.svh"

module bkv_rfifo (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire bkv_pkg::push_t push,
    output logic              room,
    output logic              out_valid,
    input  wire logic         out_ready,
    output bkv_pkg::result_t  out_res
);
    import bkv_pkg::*;

    result_t    mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_res   = mem[rd_ptr_reg];
    assign room      = (count_reg <= 3'd2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.cnt} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= push.res1;
        end
    end

    `BKV_ASSERT_SAME(a_no_overfill, push.cnt != 2'd0, count_reg <= 3'd2)
    `BKV_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= 3'd4)
    `BKV_ASSERT_NEXT(a_pop_only, pop && push.cnt == 2'd0, count_reg == $past(count_reg) - 3'd1)
    `BKV_ASSERT_SAME(a_second_is_status, push.cnt == 2'd2, push.res1.finished)

endmodule

`default_nettype wire
